>>> hw/rtl/keyed_group_score_accumulator_core_defines.svh
`ifndef KEYED_GROUP_SCORE_ACCUMULATOR_CORE_DEFINES_SVH
`define KEYED_GROUP_SCORE_ACCUMULATOR_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define KGSA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kgsa check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define KGSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kgsa check failed");

`endif

>>> hw/rtl/kgsa_pkg.sv
`timescale 1ns / 1ps

package kgsa_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef logic [31:0] user_t;
	typedef logic [63:0] topic_t;
	typedef logic signed [15:0] score_t;
	typedef logic signed [31:0] total_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam total_t TOTAL_MAX = 32'sh7fff_ffff;
	localparam total_t TOTAL_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic topic_we;
		logic total_we;
		idx_t wr_addr;
		topic_t wr_topic;
		total_t wr_total;
	} tbl_ctrl_t;

	typedef struct packed {
		topic_t topic;
		total_t total;
	} tbl_data_t;

	function automatic total_t sat_add(total_t acc, score_t s);
		logic [32:0] sum;
		sum = {acc[31], acc} + {{17{s[15]}}, s};
		if (sum[32] != sum[31]) begin
			return sum[32] ? TOTAL_MIN : TOTAL_MAX;
		end
		return total_t'(sum[31:0]);
	endfunction

	function automatic total_t widen_score(score_t s);
		return total_t'({{16{s[15]}}, s});
	endfunction

endpackage

>>> hw/rtl/kgsa_in_if.sv
`timescale 1ns / 1ps

interface kgsa_in_if;
	import kgsa_pkg::*;

	logic valid;
	logic ready;
	logic operation;
	user_t user_key;
	topic_t topic_key;
	score_t score;

	modport source (output valid, output operation, output user_key, output topic_key,
		output score, input ready);
	modport sink (input valid, input operation, input user_key, input topic_key,
		input score, output ready);
endinterface

>>> hw/rtl/kgsa_out_if.sv
`timescale 1ns / 1ps

interface kgsa_out_if;
	import kgsa_pkg::*;

	logic valid;
	logic ready;
	user_t out_user;
	topic_t out_topic;
	total_t total;
	logic group_last;
	logic overflowed;

	modport source (output valid, output out_user, output out_topic, output total,
		output group_last, output overflowed, input ready);
	modport sink (input valid, input out_user, input out_topic, input total,
		input group_last, input overflowed, output ready);
endinterface

>>> hw/rtl/keyed_group_score_accumulator_core.sv
`timescale 1ns / 1ps
// record for the open user: a linear search of the table entries (one read port, one compare)
// first record of a group: written through S_OPEN; flush: one entry per cycle while results are taken
// user change: the flush of the old group, then S_OPEN opens the new one
// one word in flight at a time; ready is high only while the sequencer waits
// arst_n clears the sequencer, entry count, open-group and overflow flags, and the result valid
// table contents are not cleared; only entries below the count are ever read

module keyed_group_score_accumulator_core (
	input logic clk,
	input logic arst_n,
	kgsa_in_if.sink records,
	kgsa_out_if.source results
);
	import kgsa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_OPEN = 4'b0010,
		S_SEARCH = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q;
	logic op_q;
	user_t user_q;
	topic_t topic_q;
	score_t score_q;
	user_t cur_user_q;
	logic have_user_q;
	logic drop_q;
	cnt_t count_q;
	cnt_t rd_idx_q;
	cnt_t rd_idx_s1;
	logic rdv_s1;
	logic out_valid_q;
	user_t out_user_q;
	topic_t out_topic_q;
	total_t out_total_q;
	logic out_last_q;
	logic out_ovf_q;

	tbl_ctrl_t tbl_ctrl;
	tbl_data_t rd_data;

	logic accept;
	logic hit;
	logic more;
	logic out_free;
	logic consume;
	logic issue;
	logic full;

	kgsa_table u_table (
		.clk(clk),
		.ctrl(tbl_ctrl),
		.rd_data(rd_data)
	);

	assign records.ready = (state_q == S_IDLE);
	assign accept = records.valid && records.ready;

	assign more = (rd_idx_q != count_q);
	assign full = (count_q == cnt_t'(TABLE_DEPTH));
	assign hit = (state_q == S_SEARCH) && rdv_s1 && (rd_data.topic == topic_q);
	assign out_free = !out_valid_q || results.ready;
	assign consume = (state_q == S_EMIT) && rdv_s1 && out_free;

	always_comb begin
		case (state_q)
			S_SEARCH: issue = more && !hit;
			S_EMIT: issue = more && (!rdv_s1 || consume);
			default: issue = 1'b0;
		endcase
	end

	always_comb begin
		tbl_ctrl = '0;
		tbl_ctrl.rd_en = issue;
		tbl_ctrl.rd_addr = rd_idx_q[IDX_W-1:0];
		case (state_q)
			S_OPEN: begin
				tbl_ctrl.topic_we = 1'b1;
				tbl_ctrl.total_we = 1'b1;
				tbl_ctrl.wr_addr = '0;
				tbl_ctrl.wr_topic = topic_q;
				tbl_ctrl.wr_total = widen_score(score_q);
			end
			S_SEARCH: begin
				tbl_ctrl.wr_topic = topic_q;
				if (hit) begin
					tbl_ctrl.total_we = 1'b1;
					tbl_ctrl.wr_addr = rd_idx_s1[IDX_W-1:0];
					tbl_ctrl.wr_total = sat_add(rd_data.total, score_q);
				end else if (!more && !rdv_s1 && !full) begin
					// no match in the table: append
					tbl_ctrl.topic_we = 1'b1;
					tbl_ctrl.total_we = 1'b1;
					tbl_ctrl.wr_addr = count_q[IDX_W-1:0];
					tbl_ctrl.wr_total = widen_score(score_q);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= records.operation;
			user_q <= records.user_key;
			topic_q <= records.topic_key;
			score_q <= records.score;
		end
		if (issue) begin
			rd_idx_s1 <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_user_q <= '0;
			have_user_q <= 1'b0;
			drop_q <= 1'b0;
			count_q <= '0;
			rd_idx_q <= '0;
			rdv_s1 <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						rdv_s1 <= 1'b0;
						if (records.operation == OP_FLUSH) begin
							state_q <= have_user_q ? S_EMIT : S_IDLE;
						end else if (!have_user_q) begin
							state_q <= S_OPEN;
						end else if (records.user_key != cur_user_q) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_OPEN: begin
					have_user_q <= 1'b1;
					cur_user_q <= user_q;
					drop_q <= 1'b0;
					count_q <= cnt_t'(1);
					state_q <= S_IDLE;
				end
				S_SEARCH: begin
					rdv_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + cnt_t'(1);
					end
					if (hit) begin
						state_q <= S_IDLE;
					end else if (!more && !rdv_s1) begin
						if (full) begin
							drop_q <= 1'b1;
						end else begin
							count_q <= count_q + cnt_t'(1);
						end
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					rdv_s1 <= issue || (rdv_s1 && !consume);
					if (issue) begin
						rd_idx_q <= rd_idx_q + cnt_t'(1);
					end
					if (!more && !rdv_s1) begin
						have_user_q <= 1'b0;
						drop_q <= 1'b0;
						count_q <= '0;
						// a record that closed the group now opens its own
						state_q <= (op_q == OP_RECORD) ? S_OPEN : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume) begin
			out_user_q <= cur_user_q;
			out_topic_q <= rd_data.topic;
			out_total_q <= rd_data.total;
			out_last_q <= (rd_idx_s1 + cnt_t'(1) == count_q);
			out_ovf_q <= drop_q;
		end
	end

	assign results.valid = out_valid_q;
	assign results.out_user = out_user_q;
	assign results.out_topic = out_topic_q;
	assign results.total = out_total_q;
	assign results.group_last = out_last_q;
	assign results.overflowed = out_ovf_q;
endmodule

>>> hw/rtl/kgsa_table.sv
`timescale 1ns / 1ps

module kgsa_table (
	input logic clk,
	input kgsa_pkg::tbl_ctrl_t ctrl,
	output kgsa_pkg::tbl_data_t rd_data
);
	import kgsa_pkg::*;

	topic_t topic_mem [TABLE_DEPTH];
	total_t total_mem [TABLE_DEPTH];
	topic_t topic_rd_q;
	total_t total_rd_q;

	always_ff @(posedge clk) begin
		if (ctrl.topic_we) begin
			topic_mem[ctrl.wr_addr] <= ctrl.wr_topic;
		end
		if (ctrl.total_we) begin
			total_mem[ctrl.wr_addr] <= ctrl.wr_total;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			topic_rd_q <= topic_mem[ctrl.rd_addr];
			total_rd_q <= total_mem[ctrl.rd_addr];
		end
	end

	assign rd_data.topic = topic_rd_q;
	assign rd_data.total = total_rd_q;
endmodule

>>> hw/rtl/kgsa_checker.sv
`timescale 1ns / 1ps
`include "keyed_group_score_accumulator_core_defines.svh"

module kgsa_checker (
	input logic clk,
	input logic arst_n,
	input logic rec_valid,
	input logic rec_ready,
	input logic rec_op,
	input logic res_valid,
	input logic res_ready,
	input kgsa_pkg::user_t res_user,
	input kgsa_pkg::topic_t res_topic,
	input kgsa_pkg::total_t res_total,
	input logic res_last,
	input logic res_ovf
);
	import kgsa_pkg::*;

	// a stalled result word holds
	`KGSA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_user) && $stable(res_topic) && $stable(res_total) && $stable(res_last) && $stable(res_ovf))

	// the sequencer is busy right after taking a score record
	`KGSA_ASSERT_NEXT(a_busy_after_accept, rec_valid && rec_ready && (rec_op == OP_RECORD), !rec_ready)

	// no new word while a group is only partly streamed out
	`KGSA_ASSERT_NOW(a_busy_mid_group, res_valid && !res_last, !rec_ready)

	// user and overflow flag stay fixed across one group
	`KGSA_ASSERT_NEXT(a_group_const, res_valid && res_ready && !res_last, !res_valid || (res_user == $past(res_user) && res_ovf == $past(res_ovf)))
endmodule

bind keyed_group_score_accumulator_core kgsa_checker u_kgsa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rec_valid(records.valid),
	.rec_ready(records.ready),
	.rec_op(records.operation),
	.res_valid(results.valid),
	.res_ready(results.ready),
	.res_user(results.out_user),
	.res_topic(results.out_topic),
	.res_total(results.total),
	.res_last(results.group_last),
	.res_ovf(results.overflowed)
);
